/* rtl/rotating_bank_swap_store_macros.svh */
// assertion macros used by the checker file of the rotating bank swap store
`ifndef ROTATING_BANK_SWAP_STORE_MACROS_SVH
`define ROTATING_BANK_SWAP_STORE_MACROS_SVH

// same-cycle implication, off while reset is held
`define RBSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbss assertion failed");

// next-cycle implication, off while reset is held
`define RBSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbss assertion failed");

// next-cycle implication that also holds across reset
`define RBSS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rbss assertion failed");

`endif

/* rtl/rbss_pkg.sv */
// shared types, field widths and entry encoding of the rotating bank swap store
package rbss_pkg;

  localparam int CLIENT_W = 4;
  localparam int IDENT_W  = 16;
  localparam int ENTRY_W  = 1 + CLIENT_W + IDENT_W;
  localparam int BANK_OW  = 2;
  localparam int SLOT_OW  = 4;
  localparam int COST_OW  = 4;

  typedef logic [ENTRY_W-1:0] entry_t;

  // every empty slot holds this one code
  localparam entry_t EMPTY_CODE = {1'b1, {(CLIENT_W + IDENT_W){1'b0}}};

  localparam logic CMD_SWAP  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  function automatic entry_t make_entry(input logic empty,
                                        input logic [CLIENT_W-1:0] client,
                                        input logic [IDENT_W-1:0] ident);
    entry_t e;
    if (empty) begin
      e = EMPTY_CODE;
    end else begin
      e = {1'b0, client, ident};
    end
    return e;
  endfunction

endpackage

/* rtl/rbss_in_if.sv */
// request and result channel interfaces of the rotating bank swap store
interface rbss_in_if;
  import rbss_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic                key_empty;
  logic [CLIENT_W-1:0] key_client;
  logic [IDENT_W-1:0]  key_ident;
  logic                new_empty;
  logic [CLIENT_W-1:0] new_client;
  logic [IDENT_W-1:0]  new_ident;

  modport source (output valid, cmd, key_empty, key_client, key_ident,
                  new_empty, new_client, new_ident, input ready);
  modport sink   (input valid, cmd, key_empty, key_client, key_ident,
                  new_empty, new_client, new_ident, output ready);
endinterface

interface rbss_out_if;
  import rbss_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [BANK_OW-1:0] bank_index;
  logic [SLOT_OW-1:0] slot_index;
  logic [COST_OW-1:0] rotate_cost;

  modport source (output valid, found, bank_index, slot_index, rotate_cost, input ready);
  modport sink   (input valid, found, bank_index, slot_index, rotate_cost, output ready);
endinterface

/* rtl/rotating_bank_swap_store.sv */
// top level of the rotating bank swap store: sequencer, head pointers and slot ram
//
// BANKS banks of SLOTS_PER_BANK slots live in one ram; each bank keeps a head
// pointer, so a rotation is a pointer move and never a data copy. After reset
// the block runs a clearing pass over all BANKS*SLOTS_PER_BANK slots (64 by
// default) that writes the empty mark to every slot, with in_chan.ready low. A
// request word then scans slots through the single ram read port, one slot a
// cycle, with the compare in the cycle after the read; a scan ends at the first
// hit, counted over banks in search order, or after the last slot as a miss,
// and its result is then loaded into the result register; a request is taken
// only while no other is being scanned. The result word waits in its own
// register, so the scan of the next request starts while it is still held; a
// finished scan waits only if that register is still full.
module rotating_bank_swap_store #(
  parameter int BANKS          = 4,
  parameter int SLOTS_PER_BANK = 16
) (
  input logic         clk,
  input logic         rst_n,
  rbss_in_if.sink     in_chan,
  rbss_out_if.source  out_chan
);
  import rbss_pkg::*;

  localparam int BW    = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int SW    = $clog2(SLOTS_PER_BANK);
  localparam int DEPTH = BANKS * SLOTS_PER_BANK;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;

  logic          cmd_r;
  entry_t        key_r;
  entry_t        repl_r;

  logic [BW-1:0] scan_bank_r;
  logic [SW-1:0] scan_slot_r;
  logic [BW-1:0] scan_cnt_r;
  logic          issue_done_r;

  logic          cmp_vld_r;
  logic [BW-1:0] cmp_bank_r;
  logic [SW-1:0] cmp_slot_r;
  logic [SW-1:0] cmp_phys_r;

  logic [SW-1:0] head_r [BANKS];
  logic [BW-1:0] ptr_r;

  logic          res_found_r;
  logic [BW-1:0] res_bank_r;
  logic [SW-1:0] res_slot_r;
  logic [SW:0]   res_cost_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [BANK_OW-1:0] out_bank_r;
  logic [SLOT_OW-1:0] out_slot_r;
  logic [COST_OW-1:0] out_cost_r;

  logic [SW-1:0] head_sel;
  logic [SW:0]   phys_sum;
  logic [SW-1:0] scan_phys;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          ram_we;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  logic          hit;
  logic [SW:0]   cost_right;
  logic [SW:0]   cost;
  logic          accept;
  logic          out_load;

  function automatic logic [BW-1:0] next_bank(input logic [BW-1:0] b);
    logic [BW-1:0] n;
    if (b == BW'(BANKS - 1)) begin
      n = '0;
    end else begin
      n = b + 1'b1;
    end
    return n;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                              input logic [SW-1:0] p);
    return AW'(int'(b) * SLOTS_PER_BANK + int'(p));
  endfunction

  // logical slot to physical slot: head plus offset, wrapped once
  assign head_sel  = head_r[scan_bank_r];
  assign phys_sum  = {1'b0, head_sel} + {1'b0, scan_slot_r};
  assign scan_phys = (phys_sum >= (SW+1)'(SLOTS_PER_BANK))
                     ? SW'(phys_sum - (SW+1)'(SLOTS_PER_BANK)) : SW'(phys_sum);
  assign rd_addr   = slot_addr(scan_bank_r, scan_phys);
  assign wr_addr   = (state_r == ST_CLEAR) ? clr_addr_r : slot_addr(cmp_bank_r, cmp_phys_r);

  assign hit       = (state_r == ST_SCAN) && cmp_vld_r && (ram_rdata == key_r);
  assign ram_we    = (state_r == ST_CLEAR) || hit;
  assign ram_wdata = (state_r == ST_CLEAR) ? EMPTY_CODE : repl_r;

  assign cost_right = (SW+1)'(SLOTS_PER_BANK) - {1'b0, cmp_slot_r};
  assign cost       = ({1'b0, cmp_slot_r} < cost_right) ? {1'b0, cmp_slot_r} : cost_right;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.bank_index  = out_bank_r;
  assign out_chan.slot_index  = out_slot_r;
  assign out_chan.rotate_cost = out_cost_r;

  rbss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || issue_done_r) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      ptr_r        <= '0;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < BANKS; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (accept) begin
        issue_done_r <= 1'b0;
        cmp_vld_r    <= 1'b0;
      end
      if (state_r == ST_SCAN) begin
        if (hit) begin
          if (cmd_r == CMD_SWAP) begin
            // rotate: the written slot becomes the head
            head_r[cmp_bank_r] <= cmp_phys_r;
          end else begin
            ptr_r <= next_bank(cmp_bank_r);
          end
        end else if (!issue_done_r) begin
          cmp_vld_r <= 1'b1;
          if (scan_slot_r == SW'(SLOTS_PER_BANK - 1) && scan_cnt_r == BW'(BANKS - 1)) begin
            issue_done_r <= 1'b1;
          end
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scan position registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_chan.cmd;
      key_r       <= (in_chan.cmd == CMD_ALLOC) ? EMPTY_CODE
                     : make_entry(in_chan.key_empty, in_chan.key_client, in_chan.key_ident);
      repl_r      <= make_entry(in_chan.new_empty, in_chan.new_client, in_chan.new_ident);
      scan_bank_r <= (in_chan.cmd == CMD_ALLOC) ? ptr_r : '0;
      scan_slot_r <= '0;
      scan_cnt_r  <= '0;
    end
    if (state_r == ST_SCAN) begin
      if (hit) begin
        res_found_r <= 1'b1;
        res_bank_r  <= cmp_bank_r;
        res_slot_r  <= cmp_slot_r;
        res_cost_r  <= (cmd_r == CMD_SWAP) ? cost : '0;
      end else if (issue_done_r) begin
        res_found_r <= 1'b0;
        res_bank_r  <= '0;
        res_slot_r  <= '0;
        res_cost_r  <= '0;
      end else begin
        cmp_bank_r <= scan_bank_r;
        cmp_slot_r <= scan_slot_r;
        cmp_phys_r <= scan_phys;
        if (scan_slot_r == SW'(SLOTS_PER_BANK - 1)) begin
          scan_slot_r <= '0;
          scan_bank_r <= next_bank(scan_bank_r);
          scan_cnt_r  <= scan_cnt_r + 1'b1;
        end else begin
          scan_slot_r <= scan_slot_r + 1'b1;
        end
      end
    end
    if (out_load) begin
      out_found_r <= res_found_r;
      out_bank_r  <= BANK_OW'(res_bank_r);
      out_slot_r  <= SLOT_OW'(res_slot_r);
      out_cost_r  <= COST_OW'(res_cost_r);
    end
  end

endmodule

/* rtl/rbss_ram.sv */
// generic simple dual-port ram, one write and one registered read
module rbss_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rbss_checker.sv */
// port-level checker of the rotating bank swap store and its bind
`include "rotating_bank_swap_store_macros.svh"

module rbss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_found,
  input logic [rbss_pkg::BANK_OW-1:0] out_bank_index,
  input logic [rbss_pkg::SLOT_OW-1:0] out_slot_index,
  input logic [rbss_pkg::COST_OW-1:0] out_rotate_cost
);
  import rbss_pkg::*;

  // a result word holds until taken
  `RBSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_bank_index) && $stable(out_slot_index) && $stable(out_rotate_cost))

  // a miss or a full store reports all-zero position and cost
  `RBSS_ASSERT_IMPL(a_miss_zero, out_valid && !out_found, out_bank_index == '0 && out_slot_index == '0 && out_rotate_cost == '0)

  // a taken request keeps the block busy for at least the next cycle
  `RBSS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // the clearing pass follows reset, no request is taken right after it
  `RBSS_ASSERT_NEXT_ALWAYS(a_clear_after_reset, !rst_n, !in_ready)

endmodule

bind rotating_bank_swap_store rbss_checker u_rbss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_found       (out_chan.found),
  .out_bank_index  (out_chan.bank_index),
  .out_slot_index  (out_chan.slot_index),
  .out_rotate_cost (out_chan.rotate_cost)
);
